FILE: hdl/mml_pkg.sv
// Shared types, constants and helpers for the masked min/max locator.
package mml_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam int PIXEL_W     = 32;
   localparam int MASK_W      = 8;
   localparam int COORD_W     = 12;
   localparam int WIDTH_REG_W = 13;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = WIDTH_REG_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_KIND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ENABLE = 2'd2;

   // Pixel kinds.
   localparam logic [KIND_W-1:0] KIND_U8  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_U16 = 2'd1;
   localparam logic [KIND_W-1:0] KIND_S32 = 2'd2;

   localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 13'd1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_bits;
      logic [MASK_W-1:0]  mask_byte;
      logic               last_pixel;
   } req_item_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] low_value;
      logic signed [PIXEL_W-1:0] high_value;
      logic [COORD_W-1:0]        min_col;
      logic [COORD_W-1:0]        min_row;
      logic [COORD_W-1:0]        max_col;
      logic [COORD_W-1:0]        max_row;
      logic                      found_any;
   } rsp_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } pos_type;

   // Zero extended value bits for the configured pixel kind; s32 and other kinds pass through.
   function automatic logic [PIXEL_W-1:0] decode_pixel(input logic [PIXEL_W-1:0] raw,
                                                       input logic [KIND_W-1:0]  kind);
      logic [PIXEL_W-1:0] value;
      case (kind)
         KIND_U8:  value = {{(PIXEL_W-8){1'b0}}, raw[7:0]};
         KIND_U16: value = {{(PIXEL_W-16){1'b0}}, raw[15:0]};
         KIND_S32: value = raw;
         default:  value = raw;
      endcase
      return value;
   endfunction

endpackage

FILE: hdl/masked_min_max_locator_core.sv
// Top level of the masked min/max locator: input register, tracking logic, result register.
//
// Takes one pixel item per clock in raster order and reports, on the item marked last,
// the smallest and largest selected pixel value with the column and row of the first
// occurrence of each, then starts a new frame. An item is held in the input register and
// the result of a last item is written into the result register as that item moves on.
// The sustained rate is one item per cycle; the only limit is the combinational compare
// and update of the running extremes. The input side keeps taking items while a result
// waits, and stalls only when a last item meets a full result register that is not being
// read. The user must write configuration through the csr port only while the block is
// idle; the block does not enforce this. A width change mid-frame takes effect from the next pixel.
module masked_min_max_locator_core #(
   parameter int MAX_WIDTH  = mml_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = mml_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mml_pkg::req_item_type            req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mml_pkg::rsp_item_type            rsp_item,
   input  logic                             csr_wr_en,
   input  logic [mml_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mml_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mml_pkg::*;

   logic [WIDTH_REG_W-1:0] image_width_ff;
   logic [KIND_W-1:0]      pixel_kind_ff;
   logic                   mask_enable_ff;

   logic         stage_valid_ff, stage_valid_in;
   req_item_type stage_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;

   logic             advance;
   logic             req_fire;
   logic             selected;
   logic [PIXEL_W-1:0] value;
   pos_type          pos;
   rsp_item_type     result;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
         pixel_kind_ff  <= KIND_U8;
         mask_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            CSR_PIXEL_KIND:  pixel_kind_ff  <= csr_wdata[KIND_W-1:0];
            CSR_MASK_ENABLE: mask_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A non-last item always moves on; a last item needs room in the result register.
   assign advance   = stage_valid_ff && (!stage_ff.last_pixel || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && stage_ff.last_pixel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff <= req_item;
      end
      if (advance && stage_ff.last_pixel) begin
         rsp_ff <= result;
      end
   end

   assign value    = decode_pixel(stage_ff.pixel_bits, pixel_kind_ff);
   assign selected = !mask_enable_ff || (stage_ff.mask_byte != '0);

   mml_pos_counter #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos_counter (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .last_pixel  (stage_ff.last_pixel),
      .image_width (image_width_ff),
      .pos         (pos)
   );

   mml_extreme_tracker u_extreme_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .selected   (selected),
      .last_pixel (stage_ff.last_pixel),
      .value      (value),
      .pos        (pos),
      .result     (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: hdl/mml_pos_counter.sv
// Raster column and row counters that give the position of the pixel in work.
module mml_pos_counter #(
   parameter int MAX_WIDTH  = mml_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = mml_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               last_pixel,
   input  logic [mml_pkg::WIDTH_REG_W-1:0]    image_width,
   output mml_pkg::pos_type                   pos
);
   import mml_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = (COL_W > COORD_W) ? COL_W : COORD_W;
   localparam int CMP_W = CNT_W + 1;
   localparam logic [CMP_W-1:0] WIDTH_LIMIT = CMP_W'(MAX_WIDTH);
   localparam int ROW_LIMIT_INT = (MAX_HEIGHT - 1 > (1 << COORD_W) - 1) ?
                                  (1 << COORD_W) - 1 : MAX_HEIGHT - 1;
   localparam logic [COORD_W-1:0] ROW_LIMIT = COORD_W'(ROW_LIMIT_INT);

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0]   width_ext;
   logic [CMP_W-1:0]   eff_width;
   logic [CMP_W-1:0]   col_next;
   logic               wrap;

   always_comb begin
      width_ext = CMP_W'(image_width);
      if (width_ext == '0) begin
         eff_width = CMP_W'(1);
      end else if (width_ext > WIDTH_LIMIT) begin
         eff_width = WIDTH_LIMIT;
      end else begin
         eff_width = width_ext;
      end
      col_next = {1'b0, col_ff} + CMP_W'(1);
      // A narrower width written mid-frame wraps at once.
      wrap = (col_next >= eff_width);

      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (last_pixel) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            if (row_ff < ROW_LIMIT) begin
               row_in = row_ff + COORD_W'(1);
            end
         end else begin
            col_in = col_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign pos.col = col_ff[COORD_W-1:0];
   assign pos.row = row_ff;

endmodule

FILE: hdl/mml_extreme_tracker.sv
// Running minimum and maximum of the selected pixels with their positions.
module mml_extreme_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           selected,
   input  logic                           last_pixel,
   input  logic [mml_pkg::PIXEL_W-1:0]    value,
   input  mml_pkg::pos_type               pos,
   output mml_pkg::rsp_item_type          result
);
   import mml_pkg::*;

   logic [PIXEL_W-1:0] low_ff, low_in;
   logic [PIXEL_W-1:0] high_ff, high_in;
   pos_type            low_pos_ff, low_pos_in;
   pos_type            high_pos_ff, high_pos_in;
   logic               seen_ff, seen_in;

   logic [PIXEL_W-1:0] low_new, high_new;
   pos_type            low_pos_new, high_pos_new;
   logic               seen_new;

   always_comb begin
      low_new      = low_ff;
      high_new     = high_ff;
      low_pos_new  = low_pos_ff;
      high_pos_new = high_pos_ff;
      seen_new     = seen_ff;
      if (selected) begin
         seen_new = 1'b1;
         // The first selected pixel of a frame seeds both extremes; after that
         // only a strictly better value replaces one, so ties keep the first.
         if (!seen_ff || ($signed(value) < $signed(low_ff))) begin
            low_new     = value;
            low_pos_new = pos;
         end
         if (!seen_ff || ($signed(value) > $signed(high_ff))) begin
            high_new     = value;
            high_pos_new = pos;
         end
      end

      if (seen_new) begin
         result.low_value  = $signed(low_new);
         result.high_value = $signed(high_new);
         result.min_col    = low_pos_new.col;
         result.min_row    = low_pos_new.row;
         result.max_col    = high_pos_new.col;
         result.max_row    = high_pos_new.row;
         result.found_any  = 1'b1;
      end else begin
         result = '0;
      end

      low_in      = low_ff;
      high_in     = high_ff;
      low_pos_in  = low_pos_ff;
      high_pos_in = high_pos_ff;
      seen_in     = seen_ff;
      if (step) begin
         if (last_pixel) begin
            low_in      = '0;
            high_in     = '0;
            low_pos_in  = '0;
            high_pos_in = '0;
            seen_in     = 1'b0;
         end else begin
            low_in      = low_new;
            high_in     = high_new;
            low_pos_in  = low_pos_new;
            high_pos_in = high_pos_new;
            seen_in     = seen_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= '0;
         high_ff     <= '0;
         low_pos_ff  <= '0;
         high_pos_ff <= '0;
         seen_ff     <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         low_pos_ff  <= low_pos_in;
         high_pos_ff <= high_pos_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

FILE: tb/mml_tb_pkg.sv
`timescale 1ns / 100ps
// Frame extremes predictor and result checker for the masked min/max locator testbench.
package mml_tb_pkg;
   import mml_pkg::*;

   localparam int ROW_LIMIT = (DEFAULT_MAX_HEIGHT - 1 > (1 << COORD_W) - 1) ?
                              (1 << COORD_W) - 1 : DEFAULT_MAX_HEIGHT - 1;

   class extremes_checker;
      logic [WIDTH_REG_W-1:0] image_width;
      logic [KIND_W-1:0]      pixel_kind;
      logic                   mask_enable;

      int unsigned            col_count;
      int unsigned            row_count;
      logic [PIXEL_W-1:0]     best_low;
      logic [PIXEL_W-1:0]     best_high;
      pos_type                low_pos;
      pos_type                high_pos;
      logic                   seen;

      rsp_item_type           expected_summaries[$];
      int unsigned            mismatch_count;
      int unsigned            pixel_count;
      int unsigned            frame_count;
      int unsigned            empty_frame_count;
      int unsigned            summary_count;

      function new();
         image_width       = IMAGE_WIDTH_RESET;
         pixel_kind        = KIND_U8;
         mask_enable       = 1'b0;
         mismatch_count    = 0;
         pixel_count       = 0;
         frame_count       = 0;
         empty_frame_count = 0;
         summary_count     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col_count = 0;
         row_count = 0;
         best_low  = '0;
         best_high = '0;
         low_pos   = '0;
         high_pos  = '0;
         seen      = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH: image_width = data;
            CSR_PIXEL_KIND:  pixel_kind  = data[KIND_W-1:0];
            CSR_MASK_ENABLE: mask_enable = data[0];
            default: ;
         endcase
      endfunction

      // Folds one accepted pixel into the running extremes; a last pixel closes the frame.
      function void take_pixel(req_item_type item);
         logic [PIXEL_W-1:0] value;
         pos_type            here;
         int unsigned        span;
         rsp_item_type       summary;
         case (pixel_kind)
            KIND_U8:  value = {24'd0, item.pixel_bits[7:0]};
            KIND_U16: value = {16'd0, item.pixel_bits[15:0]};
            default:  value = item.pixel_bits;
         endcase
         here.row = row_count[COORD_W-1:0];
         here.col = col_count[COORD_W-1:0];
         span = (image_width == 0) ? 1 :
                ((image_width > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : image_width);
         if (!mask_enable || item.mask_byte != 0) begin
            if (!seen) begin
               best_low  = value;
               best_high = value;
               low_pos   = here;
               high_pos  = here;
               seen      = 1'b1;
            end else begin
               // Only a strictly better value moves an extreme, so ties keep the first one.
               if ($signed(value) < $signed(best_low)) begin
                  best_low = value;
                  low_pos  = here;
               end
               if ($signed(value) > $signed(best_high)) begin
                  best_high = value;
                  high_pos  = here;
               end
            end
         end
         if (col_count + 1 >= span) begin
            col_count = 0;
            if (row_count < ROW_LIMIT) row_count++;
         end else begin
            col_count++;
         end
         pixel_count++;
         if (item.last_pixel) begin
            summary = '0;
            if (seen) begin
               summary.low_value  = best_low;
               summary.high_value = best_high;
               summary.min_col    = low_pos.col;
               summary.min_row    = low_pos.row;
               summary.max_col    = high_pos.col;
               summary.max_row    = high_pos.row;
               summary.found_any  = 1'b1;
            end else begin
               empty_frame_count++;
            end
            expected_summaries.push_back(summary);
            frame_count++;
            clear_frame();
         end
      endfunction

      task report_mismatch(string text);
         mismatch_count++;
         $display("MISMATCH at %0t: %s", $time, text);
      endtask

      task check_field(string label, logic [PIXEL_W-1:0] got, logic [PIXEL_W-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s of result %0d: got %0h, expected %0h",
                                      label, summary_count, got, want));
      endtask

      task compare_summary(rsp_item_type got);
         rsp_item_type want;
         if (expected_summaries.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no frame closed", summary_count));
         end else begin
            want = expected_summaries.pop_front();
            check_field("low_value", got.low_value, want.low_value);
            check_field("high_value", got.high_value, want.high_value);
            check_field("min_col", got.min_col, want.min_col);
            check_field("min_row", got.min_row, want.min_row);
            check_field("max_col", got.max_col, want.max_col);
            check_field("max_row", got.max_row, want.max_row);
            check_field("found_any", got.found_any, want.found_any);
         end
         summary_count++;
      endtask
   endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the masked min/max locator testbench: clock, reset, stimulus and verdict.
module tb_top;
   import mml_pkg::*;
   import mml_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 450;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned     cycle_count     = 0;
   int unsigned     burst_left      = 0;
   int unsigned     csr_write_count = 0;
   extremes_checker extremes        = new();

   masked_min_max_locator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without completing.", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Values are read before the edge's updates land, so these see what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) extremes.take_pixel(req_item);
         if (rsp_valid && rsp_ready) extremes.compare_summary(rsp_item);
         if (csr_wr_en) extremes.write_register(csr_index, csr_wdata);
      end
   end

   // The receiver cycles through steady, random, periodic and mostly stalled stretches.
   always @(negedge clock) begin
      case ((cycle_count / 97) % 4)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= ((cycle_count % 5) < 3);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Called at a falling edge; returns at one after the item is taken and any idle gap.
   task automatic send_pixel(input logic [PIXEL_W-1:0] bits, input logic [MASK_W-1:0] mask,
                             input logic is_last);
      req_item_type item;
      item.pixel_bits = bits;
      item.mask_byte  = mask;
      item.last_pixel = is_last;
      req_item  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      end
   endtask

   // Leaves the write enable high; the caller lowers it after its last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      csr_write_count++;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] width, input logic [KIND_W-1:0] kind,
                             input logic mask_on);
      write_register(CSR_IMAGE_WIDTH, width);
      write_register(CSR_PIXEL_KIND, CSR_DATA_W'(kind));
      write_register(CSR_MASK_ENABLE, CSR_DATA_W'(mask_on));
      csr_wr_en <= 1'b0;
   endtask

   // Waits for every closed frame to be reported, then lets any pixel still inside settle.
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (extremes.expected_summaries.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mixes fully random words with narrow values that force ties in each pixel kind.
   function automatic logic [PIXEL_W-1:0] pick_pixel();
      logic [PIXEL_W-1:0] r;
      r = $urandom();
      case ($urandom_range(0, 3))
         0: return r;
         1: return {r[31:8], 8'($urandom_range(0, 3))};
         2: return {r[31:16], 16'($urandom_range(0, 3))};
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'h0000_0000;
               default: return 32'($urandom_range(0, 2)) - 32'd1;
            endcase
         end
      endcase
   endfunction

   task automatic send_frame(input int unsigned length, input bit closed, input bit unmasked);
      for (int i = 0; i < length; i++)
         send_pixel(pick_pixel(),
                    (unmasked || $urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                    closed && (i == length - 1));
   endtask

   initial begin
      int unsigned random_items;
      int unsigned frames;
      int unsigned length;
      logic [CSR_DATA_W-1:0] width;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: one-pixel rows, u8, no masking; high bits of the word are ignored.
      send_pixel(32'hFFFF_FFAB, 8'h00, 1'b1);
      drain();

      // Width zero acts as one, and the spare kind code behaves as s32.
      write_register(CSR_UNUSED, 13'h1FFF);
      set_config(13'd0, KIND_UNUSED, 1'b1);
      send_pixel(32'h7FFF_FFFF, 8'h80, 1'b0);
      send_pixel(32'h8000_0000, 8'h01, 1'b0);
      send_pixel(32'h8000_0000, 8'hFF, 1'b0);
      send_pixel(32'h7FFF_FFFF, 8'h01, 1'b0);
      send_pixel(32'h1234_5678, 8'h00, 1'b1);
      // Nothing selected in this frame.
      send_pixel(32'h0000_0005, 8'h00, 1'b0);
      send_pixel(32'h0000_0006, 8'h00, 1'b1);
      drain();

      // Width beyond the limit clamps; u16 values are zero extended.
      set_config(13'h1FFF, KIND_U16, 1'b0);
      send_pixel(32'hFFFF_0000, 8'h00, 1'b0);
      send_pixel(32'h0001_FFFF, 8'h00, 1'b0);
      send_pixel(32'h0000_FFFF, 8'h00, 1'b1);
      drain();

      // The frame is left open while width and masking change under it.
      set_config(13'd3, KIND_S32, 1'b1);
      send_pixel(32'h0000_0010, 8'h01, 1'b0);
      send_pixel(32'hFFFF_FFF0, 8'h00, 1'b0);
      send_pixel(32'h0000_0020, 8'h40, 1'b0);
      send_pixel(32'hFFFF_FFE0, 8'h02, 1'b0);
      send_pixel(32'h0000_0001, 8'h00, 1'b0);
      drain();
      set_config(13'd2, KIND_S32, 1'b0);
      send_pixel(32'hFFFF_FF00, 8'h00, 1'b0);
      send_pixel(32'h0000_0100, 8'h00, 1'b1);
      drain();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       width = 13'd0;
            1:       width = 13'd4096;
            2:       width = 13'($urandom_range(4097, 8191));
            default: width = 13'($urandom_range(1, 12));
         endcase
         set_config(width, KIND_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         frames = $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            length = $urandom_range(1, 24);
            // The final frame of a phase is sometimes left open across the next settings.
            send_frame(length, !(f == frames - 1 && $urandom_range(0, 3) == 0),
                       $urandom_range(0, 9) == 0);
            random_items += length;
         end
         drain();
      end

      if (extremes.expected_summaries.size() != 0)
         extremes.report_mismatch($sformatf("%0d frame results never arrived",
                                            extremes.expected_summaries.size()));
      $display("Ran %0d pixels in %0d frames (%0d with nothing selected), %0d register writes.",
               extremes.pixel_count, extremes.frame_count, extremes.empty_frame_count,
               csr_write_count);
      $display("Covered all pixel kinds, masking on and off, and clamped widths.");
      if (extremes.mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
